/* hw/rtl/u8sd_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_DEPTH  = 4;
    localparam int CP_W        = 31;

    // One unit of output work: optional raw flush of the lead and buffered
    // continuation bytes, then an optional final result.
    typedef struct packed {
        logic [7:0]                 lead;
        logic [PEND_DEPTH-1:0][5:0] pend;
        logic                       has_flush;
        logic [2:0]                 npend;
        logic                       has_final;
        logic [CP_W-1:0]            final_value;
        logic                       final_raw;
        logic                       end_flag;
    } job_t;

endpackage

/* hw/rtl/u8sd_front.sv */
// Front end: accepts bytes, tracks the open sequence and issues output jobs.
`timescale 1ns / 1ps

module u8sd_front import u8sd_pkg::*; #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_string_end_in,
    input  logic       q_full,
    output logic       push,
    output job_t       job
);

    localparam logic [2:0] MAX_LEN = 3'(MAX_SEQ_BYTES);

    logic [7:0]                 lead_reg, lead_next;
    logic [2:0]                 need_reg, need_next;
    logic [2:0]                 rcnt_reg, rcnt_next;
    logic [CP_W-1:0]            acc_reg, acc_next;
    logic [PEND_DEPTH-1:0][5:0] pend_reg, pend_next;

    logic            accept;
    logic            is_cont;
    logic            fresh;
    logic [2:0]      rc_inc;
    logic [2:0]      slot;
    logic [CP_W-1:0] acc_shift;
    logic [2:0]      len;
    logic [6:0]      mask;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign is_cont = (s_byte_in[7:6] == 2'b10);
    assign rc_inc  = rcnt_reg + 3'd1;
    assign slot    = rc_inc - 3'd2;
    assign acc_shift = {acc_reg[CP_W-7:0], s_byte_in[5:0]};

    always_comb begin
        len  = 3'd0;
        mask = 7'h00;
        if (s_byte_in[7] == 1'b0) begin
            len = 3'd1; mask = 7'h7f;
        end else if (s_byte_in[7:5] == 3'b110) begin
            len = 3'd2; mask = 7'h1f;
        end else if (s_byte_in[7:4] == 4'b1110) begin
            len = 3'd3; mask = 7'h0f;
        end else if (s_byte_in[7:3] == 5'b11110) begin
            len = 3'd4; mask = 7'h07;
        end else if (s_byte_in[7:2] == 6'b111110) begin
            len = 3'd5; mask = 7'h03;
        end else if (s_byte_in[7:1] == 7'b1111110) begin
            len = 3'd6; mask = 7'h01;
        end
    end

    always_comb begin
        lead_next = lead_reg;
        need_next = need_reg;
        rcnt_next = rcnt_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        fresh     = 1'b1;

        job             = '0;
        job.lead        = lead_reg;
        job.pend        = pend_reg;
        job.end_flag    = s_string_end_in;

        if (need_reg != 3'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (rc_inc >= need_reg) begin
                    job.has_final   = 1'b1;
                    job.final_value = acc_shift;
                    need_next = 3'd0;
                    rcnt_next = 3'd0;
                    acc_next  = '0;
                end else if (s_string_end_in) begin
                    job.has_flush   = 1'b1;
                    job.npend       = slot;
                    job.has_final   = 1'b1;
                    job.final_raw   = 1'b1;
                    job.final_value = {{(CP_W-8){1'b0}}, s_byte_in};
                    need_next = 3'd0;
                    rcnt_next = 3'd0;
                    acc_next  = '0;
                end else begin
                    acc_next  = acc_shift;
                    rcnt_next = rc_inc;
                    pend_next[slot[1:0]] = s_byte_in[5:0];
                end
            end else begin
                job.has_flush = 1'b1;
                job.npend     = rcnt_reg - 3'd1;
                need_next = 3'd0;
                rcnt_next = 3'd0;
                acc_next  = '0;
            end
        end

        if (fresh) begin
            if (len == 3'd0 || len > MAX_LEN || s_string_end_in || len == 3'd1) begin
                job.has_final   = 1'b1;
                job.final_raw   = (len != 3'd1);
                job.final_value = {{(CP_W-8){1'b0}}, s_byte_in};
            end else begin
                lead_next = s_byte_in;
                need_next = len;
                rcnt_next = 3'd1;
                acc_next  = {{(CP_W-7){1'b0}}, s_byte_in[6:0] & mask};
            end
        end
    end

    assign push = accept && (job.has_flush || job.has_final);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= '0;
            need_reg <= '0;
            rcnt_reg <= '0;
            acc_reg  <= '0;
        end else if (accept) begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            rcnt_reg <= rcnt_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

/* hw/rtl/u8sd_queue.sv */
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module u8sd_queue import u8sd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/u8sd_back.sv */
// Output sequencer: walks each job and drives the registered result channel.
`timescale 1ns / 1ps

module u8sd_back import u8sd_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  job_t            head_job,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_raw_fallback,
    output logic            m_last_of_run,
    output logic            m_string_done
);

    logic [2:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic [CP_W-1:0] cp_reg;
    logic            raw_reg, last_reg, done_reg;

    logic [2:0]      total;
    logic [2:0]      idx_m1;
    logic            is_last;
    logic            load;
    logic [CP_W-1:0] sel_value;
    logic            sel_raw;

    assign total   = {2'b00, head_job.has_flush} + head_job.npend
                   + {2'b00, head_job.has_final};
    assign idx_m1  = idx_reg - 3'd1;
    assign is_last = (idx_reg == total - 3'd1);
    assign load    = head_valid && (!valid_reg || m_ready);
    assign pop     = load && is_last;

    always_comb begin
        if (head_job.has_flush && idx_reg == 3'd0) begin
            sel_value = {{(CP_W-8){1'b0}}, head_job.lead};
            sel_raw   = 1'b1;
        end else if (idx_reg != 3'd0 && idx_reg <= head_job.npend) begin
            sel_value = {{(CP_W-8){1'b0}}, 2'b10, head_job.pend[idx_m1[1:0]]};
            sel_raw   = 1'b1;
        end else begin
            sel_value = head_job.final_value;
            sel_raw   = head_job.final_raw;
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg   <= sel_value;
            raw_reg  <= sel_raw;
            last_reg <= is_last;
            done_reg <= is_last && head_job.end_flag;
        end
    end

    assign m_valid        = valid_reg;
    assign m_code_point   = cp_reg;
    assign m_raw_fallback = raw_reg;
    assign m_last_of_run  = last_reg;
    assign m_string_done  = done_reg;

endmodule

/* hw/rtl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder with raw-byte fallback.
// Takes one byte per cycle and emits one code point per complete sequence of 1 to
// MAX_SEQ_BYTES (default 6) bytes; longer leads count as invalid. Malformed input comes out
// as flagged raw bytes (zero-extended). The front end accepts a byte every cycle while the
// 4-entry job queue has room; the output sequencer drives one result per cycle whenever
// m_ready allows, so a malformed sequence (up to 6 results for one byte) may back-pressure
// the input once the queue fills. Results pass through the job queue and then the output
// register. Overlong and surrogate forms are not checked.
`timescale 1ns / 1ps

module utf8_stream_decoder import u8sd_pkg::*; #(
    parameter int MAX_SEQ_BYTES = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_byte_in,
    input  logic            s_string_end_in,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_raw_fallback,
    output logic            m_last_of_run,
    output logic            m_string_done
);

    logic q_full, q_push, q_valid, q_pop;
    job_t front_job, head_job;

    u8sd_front #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_string_end_in (s_string_end_in),
        .q_full          (q_full),
        .push            (q_push),
        .job             (front_job)
    );

    u8sd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (front_job),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (head_job),
        .pop        (q_pop)
    );

    u8sd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (q_valid),
        .head_job       (head_job),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_point   (m_code_point),
        .m_raw_fallback (m_raw_fallback),
        .m_last_of_run  (m_last_of_run),
        .m_string_done  (m_string_done)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench of the UTF-8 stream decoder with raw-byte fallback.
`timescale 1ns / 1ps

module tb;
    import u8sd_pkg::*;

    localparam int SEQ_MAX        = 6;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int DIR_ROWS       = 26;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
        logic            last;
        logic            done;
    } cp_result_t;

    typedef struct packed {
        logic [7:0]      byte_v;
        logic            str_end;
        logic            typed;
        logic [CP_W-1:0] cp;
        logic            raw;
    } stim_row_t;

    // typed rows carry their result; the rest go through the decoder model
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 31'h00, 1'b0},
        '{8'h7f, 1'b1, 1'b1, 31'h7f, 1'b0},
        '{8'h80, 1'b0, 1'b1, 31'h80, 1'b1},
        '{8'hfe, 1'b0, 1'b1, 31'hfe, 1'b1},
        '{8'hff, 1'b0, 1'b1, 31'hff, 1'b1},
        '{8'hc3, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'ha9, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hfd, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hfc, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hf0, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 31'h0, 1'b0},
        '{8'hc3, 1'b1, 1'b1, 31'hc3, 1'b1},
        '{8'he2, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'h82, 1'b0, 1'b0, 31'h0, 1'b0},
        '{8'hac, 1'b1, 1'b0, 31'h0, 1'b0}
    };

    logic            aclk            = 1'b0;
    logic            aresetn         = 1'b0;
    logic            s_valid         = 1'b0;
    logic            s_ready;
    logic [7:0]      s_byte_in       = 8'h00;
    logic            s_string_end_in = 1'b0;
    logic            m_valid;
    logic            m_ready         = 1'b0;
    logic [CP_W-1:0] m_code_point;
    logic            m_raw_fallback;
    logic            m_last_of_run;
    logic            m_string_done;

    // decoder model state
    logic [7:0]      seq_lead = '0;
    logic [2:0]      seq_len  = '0;
    logic [2:0]      seq_cnt  = '0;
    logic [CP_W-1:0] seq_acc  = '0;
    logic [5:0]      seq_pend [PEND_DEPTH];

    cp_result_t decoded [$];
    cp_result_t cp_expected [$];

    int   err_cnt     = 0;
    int   items_sent  = 0;
    int   hold_req    = 0;
    logic tx_quiet    = 1'b0;
    logic rx_quiet    = 1'b0;

    utf8_stream_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_string_end_in (s_string_end_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_raw_fallback  (m_raw_fallback),
        .m_last_of_run   (m_last_of_run),
        .m_string_done   (m_string_done)
    );

    always #1 aclk = ~aclk;

    function automatic void emit(input logic [CP_W-1:0] v, input logic raw);
        decoded.push_back('{v, raw, 1'b0, 1'b0});
    endfunction

    function automatic void close_seq();
        seq_len = '0;
        seq_cnt = '0;
        seq_acc = '0;
    endfunction

    function automatic void flush_seq(input int count);
        emit(CP_W'(seq_lead), 1'b1);
        for (int i = 0; i < count && i < PEND_DEPTH; i++)
            emit(CP_W'({2'b10, seq_pend[i]}), 1'b1);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic e);
        logic       fresh;
        int         len;
        logic [6:0] msk;
        logic [2:0] slot;
        decoded.delete();
        fresh = 1'b1;
        if (seq_len != 0) begin
            if (b[7:6] == 2'b10) begin
                fresh = 1'b0;
                seq_acc = {seq_acc[CP_W-7:0], b[5:0]};
                seq_cnt = seq_cnt + 3'd1;
                if (seq_cnt >= seq_len) begin
                    emit(seq_acc, 1'b0);
                    close_seq();
                end else if (e) begin
                    flush_seq(int'(seq_cnt) - 2);
                    emit(CP_W'(b), 1'b1);
                    close_seq();
                end else begin
                    slot = seq_cnt - 3'd2;
                    seq_pend[slot[1:0]] = b[5:0];
                end
            end else begin
                flush_seq(int'(seq_cnt) - 1);
                close_seq();
            end
        end
        if (fresh) begin
            casez (b)
                8'b0???????: begin len = 1; msk = 7'h7f; end
                8'b110?????: begin len = 2; msk = 7'h1f; end
                8'b1110????: begin len = 3; msk = 7'h0f; end
                8'b11110???: begin len = 4; msk = 7'h07; end
                8'b111110??: begin len = 5; msk = 7'h03; end
                8'b1111110?: begin len = 6; msk = 7'h01; end
                default: begin len = 0; msk = 7'h00; end
            endcase
            if (len == 0 || len > SEQ_MAX) begin
                emit(CP_W'(b), 1'b1);
            end else if (len == 1) begin
                emit(CP_W'(b), 1'b0);
            end else if (e) begin
                emit(CP_W'(b), 1'b1);
            end else begin
                seq_lead = b;
                seq_len  = 3'(len);
                seq_cnt  = 3'd1;
                seq_acc  = CP_W'(b & {1'b0, msk});
            end
        end
        if (decoded.size() > 0) begin
            decoded[decoded.size()-1].last = 1'b1;
            decoded[decoded.size()-1].done = e;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_result();
        cp_result_t want;
        if (cp_expected.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(m_code_point), 32'h0);
            return;
        end
        want = cp_expected.pop_front();
        if (m_code_point !== want.cp)
            report_mismatch("code_point", 32'(m_code_point), 32'(want.cp));
        if (m_raw_fallback !== want.raw)
            report_mismatch("raw_fallback", 32'(m_raw_fallback), 32'(want.raw));
        if (m_last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(m_last_of_run), 32'(want.last));
        if (m_string_done !== want.done)
            report_mismatch("string_done", 32'(m_string_done), 32'(want.done));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result();
    end

    // result side pacing; a hold request stalls the output for a long stretch
    initial begin : rx_pacing
        int n;
        int hold_seen;
        hold_seen = 0;
        @(posedge aclk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 20);
                while (n > 0 && hold_req == hold_seen) begin
                    @(posedge aclk);
                    n--;
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic e,
                             input logic typed = 1'b0,
                             input logic [CP_W-1:0] cp = '0,
                             input logic raw = 1'b0);
        s_valid         <= 1'b1;
        s_byte_in       <= b;
        s_string_end_in <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        decode_byte(b, e);
        if (typed)
            cp_expected.push_back('{cp, raw, 1'b1, e});
        else
            foreach (decoded[i]) cp_expected.push_back(decoded[i]);
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // one character: well formed, cut short, or a stray byte
    task automatic gen_char(input logic last, input logic allow_bad);
        int         len;
        int         k;
        int         kind;
        logic [7:0] lead;
        kind = allow_bad ? $urandom_range(0, 9) : 0;
        len  = $urandom_range(1, 6);
        case (len)
            1: lead = {1'b0, 7'($urandom)};
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            4: lead = {5'b11110, 3'($urandom)};
            5: lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
        endcase
        if (kind == 9) begin
            send_item(8'($urandom_range(0, 255)), last);
        end else begin
            k = (kind >= 7 && len > 1) ? $urandom_range(1, len - 1) : len;
            send_item(lead, last && k == 1);
            for (int i = 2; i <= k; i++)
                send_item({2'b10, 6'($urandom)}, last && i == k);
        end
    endtask

    task automatic gen_string(input logic allow_bad);
        int n;
        n = $urandom_range(1, 6);
        for (int i = 1; i <= n; i++)
            gen_char(i == n, allow_bad);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].byte_v, DIRECTED[r].str_end, DIRECTED[r].typed,
                      DIRECTED[r].cp, DIRECTED[r].raw);

        // sender waits for every result before the back-pressure phase
        s_valid <= 1'b0;
        while (cp_expected.size() != 0) @(posedge aclk);

        tx_quiet = 1'b1;
        hold_req++;
        while (items_sent < 50) gen_string(1'b0);
        tx_quiet = 1'b0;

        while (items_sent < 110) gen_string(1'b1);

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        while (items_sent < 125) gen_string(1'b1);

        s_valid <= 1'b0;
        while (cp_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("[utf8_stream_decoder] OK");
        else
            $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

endmodule
